[rtl/mts_pkg.sv]
`timescale 1ns / 1ps

package mts_pkg;

	// fixed field widths of the payload and the apb port
	localparam int DATA_W    = 32;
	localparam int CAP_W     = 9;
	localparam int CNT_OUT_W = 9;
	localparam int ADDR_W    = 3;
	localparam int PDATA_W   = 32;

	// default stack depth and capacity register reset
	localparam int              DEPTH_DEF = 256;
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	// register index as seen on paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_OVERFLOW  = 2'd1,
		STATUS_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] popped_value;
		logic signed [DATA_W-1:0] top_value;
		logic signed [DATA_W-1:0] min_value;
		logic                     is_empty;
		logic                     is_full;
		status_t                  status;
		logic [CNT_OUT_W-1:0]     entry_count;
	} out_item_t;

	// push and pop strobes for one stack
	typedef struct packed {
		logic push;
		logic pop;
	} stack_cmd_t;

endpackage

[rtl/mts_stack.sv]
`timescale 1ns / 1ps

module mts_stack #(
	parameter int DEPTH = mts_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mts_pkg::stack_cmd_t               cmd,
	input  logic signed [mts_pkg::DATA_W-1:0] wdata,
	output logic signed [mts_pkg::DATA_W-1:0] top,
	output logic signed [mts_pkg::DATA_W-1:0] top_next,
	output logic [$clog2(DEPTH+1)-1:0]        count,
	output logic [$clog2(DEPTH+1)-1:0]        count_next
);
	import mts_pkg::*;

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	// entry storage, every pushed word lands here at its index
	logic signed [DATA_W-1:0] mem_q [DEPTH];

	// cached top, entry below it and a prefetch of the one below that
	logic signed [DATA_W-1:0] top_q;
	logic signed [DATA_W-1:0] below_q;
	logic signed [DATA_W-1:0] rd_q;
	logic [CNT_W-1:0]         count_q;

	logic [CNT_W-1:0] rd_diff;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;

	// next count and top
	always_comb begin
		count_next = count_q;
		top_next   = top_q;
		if (cmd.push) begin
			count_next = count_q + CNT_W'(1);
			top_next   = wdata;
		end else if (cmd.pop) begin
			count_next = count_q - CNT_W'(1);
			top_next   = below_q;
		end
	end

	// prefetch address is three below the next count
	assign rd_diff = count_next - CNT_W'(3);
	assign rd_addr = rd_diff[AW-1:0];
	assign wr_addr = count_q[AW-1:0];

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[wr_addr] <= wdata;
		end
		rd_q <= mem_q[rd_addr];
	end

	// top cache shifts with each push and pop
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q   <= wdata;
			below_q <= top_q;
		end else if (cmd.pop) begin
			top_q   <= below_q;
			below_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	assign top   = top_q;
	assign count = count_q;

endmodule

[rtl/min_tracking_stack_top.sv]
`timescale 1ns / 1ps

// Bounded LIFO of signed words that also reports its current minimum.
// Input channel (in_valid/in_ready/in_data) carries one push or pop per
// transfer; output channel (out_valid/out_ready/out_data) returns one result
// per input transfer: popped word, new top, minimum, flags, status and count.
// Each item passes the input register, then the output register; one item
// per cycle unless the receiver stalls. Each item touches only the cached
// top entries, and the store prefetches the entry two below the top.
// The user must write the capacity register (APB byte address 0) only while
// the block is idle; the block does not enforce this. It resets to 256 and
// is clamped to 1..DEPTH. Reset empties both the value stack and the minima
// stack; store contents are not cleared since entries are read only after
// being written. When the receiver stalls, the result stays in the output
// register, one more input is held in the input register, and in_ready drops.
module min_tracking_stack_top #(
	parameter int DEPTH = mts_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  mts_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mts_pkg::out_item_t            out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mts_pkg::ADDR_W-1:0]    paddr,
	input  logic [mts_pkg::PDATA_W-1:0]   pwdata,
	output logic [mts_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import mts_pkg::*;

	localparam int CNT_W = $clog2(DEPTH+1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// input register and output register
	logic      s1_valid_q;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_data_q;

	logic [CAP_W-1:0] cap_q;
	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] cap_eff;
	logic [CMP_W-1:0] depth_ext;

	logic       fire;
	logic       is_push;
	logic       overflow;
	logic       underflow;
	stack_cmd_t v_cmd;
	stack_cmd_t m_cmd;

	logic signed [DATA_W-1:0] v_top;
	logic signed [DATA_W-1:0] v_top_n;
	logic signed [DATA_W-1:0] m_top;
	logic signed [DATA_W-1:0] m_top_n;
	logic [CNT_W-1:0]         v_count;
	logic [CNT_W-1:0]         v_count_n;
	logic [CNT_W-1:0]         m_count;
	logic [CNT_W-1:0]         m_count_n;
	out_item_t                res;

	// handshake: the held item moves on when the output register frees up
	assign fire     = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid_q <= 1'b1;
		end else if (fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// capacity register on the apb port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

	// clamp capacity to 1..DEPTH
	assign cap_ext   = CMP_W'(cap_q);
	assign depth_ext = CMP_W'(DEPTH);
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_ext > depth_ext) begin
			cap_eff = depth_ext;
		end else begin
			cap_eff = cap_ext;
		end
	end

	// decide push and pop on both stacks
	assign is_push   = (item_s1.op == OP_PUSH);
	assign overflow  = is_push && (CMP_W'(v_count) >= cap_eff);
	assign underflow = !is_push && (v_count == '0);

	assign v_cmd.push = fire && is_push && !overflow;
	assign v_cmd.pop  = fire && !is_push && !underflow;
	assign m_cmd.push = v_cmd.push && ((m_count == '0) || (item_s1.push_value <= m_top));
	assign m_cmd.pop  = v_cmd.pop && (m_count != '0) && (m_top == v_top);

	mts_stack #(.DEPTH(DEPTH)) u_values (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (v_cmd),
		.wdata      (item_s1.push_value),
		.top        (v_top),
		.top_next   (v_top_n),
		.count      (v_count),
		.count_next (v_count_n)
	);

	mts_stack #(.DEPTH(DEPTH)) u_minima (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (m_cmd),
		.wdata      (item_s1.push_value),
		.top        (m_top),
		.top_next   (m_top_n),
		.count      (m_count),
		.count_next (m_count_n)
	);

	// result fields describe the stack after this item
	always_comb begin
		res.popped_value = v_cmd.pop ? v_top : '0;
		res.top_value    = (v_count_n != '0) ? v_top_n : '0;
		res.min_value    = (v_count_n != '0 && m_count_n != '0) ? m_top_n : '0;
		res.is_empty     = (v_count_n == '0);
		res.is_full      = (CMP_W'(v_count_n) >= cap_eff);
		res.entry_count  = CNT_OUT_W'(v_count_n);
		if (overflow) begin
			res.status = STATUS_OVERFLOW;
		end else if (underflow) begin
			res.status = STATUS_UNDERFLOW;
		end else begin
			res.status = STATUS_OK;
		end
	end

	// output register holds the result until the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
